/* src/pip_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// pip_pkg: shared definitions for the point-in-polygon test unit
// Sizes, command codes and the queue entry type used by the front and back.
// ============================================================================
package pip_pkg;

    localparam int MAX_VERTICES      = 64;
    localparam int COORD_WIDTH       = 16;
    localparam int MIN_POLY_VERTICES = 3;

    // Fixed field widths of the item and the register.
    localparam int CMD_W   = 1;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;

    // Derived sizes.
    localparam int ADDR_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int VERT_W  = 2 * COORD_WIDTH;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TEST  = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]              command;
        logic [IDX_W-1:0]              vertex_index;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } pip_item_t;

endpackage

/* src/pip_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// pip_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pip_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// pip_front: input acceptance and command queue
// Takes input beats, drops writes to slots beyond the store, and queues the
// rest for the back end.
// ============================================================================
module pip_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pip_pkg::CMD_W-1:0]     command,
    input  logic [pip_pkg::IDX_W-1:0]     vertex_index,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
    output logic                          q_valid,
    output pip_pkg::pip_item_t            q_item,
    input  logic                          q_pop
);
    import pip_pkg::*;

    pip_item_t        entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;
    logic             accept;
    logic             keep;
    logic             push;
    logic             pop;

    assign in_stall = (count_reg == Q_CW'(Q_DEPTH));
    assign accept   = in_valid && !in_stall;
    // A write to a slot that does not exist is consumed and discarded.
    assign keep     = (command == CMD_TEST) || (int'(vertex_index) < MAX_VERTICES);
    assign push     = accept && keep;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].command      <= command;
            entry_reg[wr_ptr_reg].vertex_index <= vertex_index;
            entry_reg[wr_ptr_reg].coord_x      <= coord_x;
            entry_reg[wr_ptr_reg].coord_y      <= coord_y;
        end
    end

endmodule

/* src/pip_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// pip_back: vertex store and edge-walking crossing test
// Executes queued writes into the vertex RAM and walks all edges for a test,
// one edge per cycle through a three-stage compare pipeline.
// ============================================================================
module pip_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pip_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  logic                            q_valid,
    input  pip_pkg::pip_item_t              q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            inside_res
);
    import pip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [COUNT_W-1:0]             vertex_count_reg;
    logic [CNT_W-1:0]               n_eff;
    logic [CNT_W-1:0]               n_reg, n_next;
    logic [CNT_W-1:0]               step_reg, step_next;
    logic [CNT_W-1:0]               rd_index;
    logic                           rd_en;
    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [VERT_W-1:0]              ram_rdata;

    logic signed [COORD_WIDTH-1:0]  px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0]  prev_x_reg, prev_y_reg;
    logic signed [COORD_WIDTH-1:0]  cur_x, cur_y;

    logic                           p0_v_reg, p0_first_reg;
    logic                           straddle;
    logic                           s1_v_reg;
    logic signed [DIFF_W-1:0]       a_reg, b_reg, c_reg, d_reg;
    logic                           s1_neg_reg;
    logic                           s2_v_reg;
    logic signed [PROD_W-1:0]       p1_reg, p2_reg;
    logic                           s2_neg_reg;
    logic                           crosses;
    logic                           acc_reg;

    logic                           out_valid_reg;
    logic                           inside_reg;
    logic                           take;
    logic                           drained;
    logic                           start_test;
    logic                           short_test;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    assign n_eff = (int'(vertex_count_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                            : CNT_W'(vertex_count_reg);

    // ---------------------------------------------------------------- dispatch
    // Writes run even while a result waits; a test needs the result slot free.
    assign take  = (state_reg == S_IDLE) && q_valid &&
                   ((q_item.command == CMD_WRITE) || !out_valid_reg);
    assign q_pop = take;

    assign start_test = take && (q_item.command == CMD_TEST);
    assign short_test = start_test && (int'(n_eff) < MIN_POLY_VERTICES);

    assign ram_we    = take && (q_item.command == CMD_WRITE);
    assign ram_waddr = ADDR_W'(q_item.vertex_index);

    // Read order: last vertex first, then 0 .. n-1.
    assign rd_en     = (state_reg == S_READ);
    assign rd_index  = (step_reg == '0) ? (n_reg - 1'b1) : (step_reg - 1'b1);
    assign ram_raddr = rd_index[ADDR_W-1:0];

    pip_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({q_item.coord_x, q_item.coord_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign drained = !p0_v_reg && !s1_v_reg && !s2_v_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_test && !short_test)
                begin
                    state_next = S_READ;
                    step_next  = '0;
                    n_next     = n_eff;
                end
            end
            S_READ:
            begin
                if (step_reg == n_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (drained)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            n_reg     <= n_next;
        end
    end

    // ---------------------------------------------------------------- pipeline
    assign cur_x    = ram_rdata[VERT_W-1:COORD_WIDTH];
    assign cur_y    = ram_rdata[COORD_WIDTH-1:0];
    // Edge (i, j) with i the vertex just read and j the one before it.
    assign straddle = (cur_y > py_reg) != (prev_y_reg > py_reg);
    assign crosses  = s2_neg_reg ? (p1_reg > p2_reg) : (p1_reg < p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg      <= 1'b0;
            p0_first_reg  <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p0_v_reg     <= rd_en;
            p0_first_reg <= rd_en && (step_reg == '0);
            s1_v_reg     <= p0_v_reg && !p0_first_reg && straddle;
            s2_v_reg     <= s1_v_reg;
            if (start_test)
            begin
                acc_reg <= 1'b0;
            end
            else if (s2_v_reg && crosses)
            begin
                acc_reg <= !acc_reg;
            end

            if (short_test || ((state_reg == S_DRAIN) && drained))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_test)
        begin
            px_reg <= q_item.coord_x;
            py_reg <= q_item.coord_y;
        end
        if (p0_v_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        // Stage 1: differences.
        a_reg      <= DIFF_W'(px_reg) - DIFF_W'(cur_x);
        b_reg      <= DIFF_W'(prev_y_reg) - DIFF_W'(cur_y);
        c_reg      <= DIFF_W'(prev_x_reg) - DIFF_W'(cur_x);
        d_reg      <= DIFF_W'(py_reg) - DIFF_W'(cur_y);
        s1_neg_reg <= (prev_y_reg < cur_y);
        // Stage 2: exact products.
        p1_reg     <= a_reg * b_reg;
        p2_reg     <= c_reg * d_reg;
        s2_neg_reg <= s1_neg_reg;
        // Result slot.
        if (short_test)
        begin
            inside_reg <= 1'b0;
        end
        else if ((state_reg == S_DRAIN) && drained)
        begin
            inside_reg <= acc_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    // ---------------------------------------------------------------- checks
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!p0_v_reg && !s1_v_reg && !s2_v_reg))
        else $error("edge pipeline busy while back end is idle");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("vertex write during an edge walk");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DRAIN) && drained) |-> !out_valid_reg)
        else $error("test finished while previous result still pending");

    a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (step_reg <= n_reg))
        else $error("edge walk ran past the vertex count");

endmodule

/* src/point_in_polygon_test_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// point_in_polygon_test_unit: even-odd ray-crossing point-in-polygon test
// Stores polygon vertices and tests query points against the stored polygon.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------------
//  cfg       in         cfg_wr_en              cfg_wr_data (vertex_count)
//  in        in         in_valid / in_stall    command, vertex_index, coord_x, coord_y
//  out       out        out_valid / out_stall  inside_res
//
//  A write beat is executed from the idle state and gives no result.
//  With n the vertex_count capped at the store size, a test beat holds the
//  back end from dispatch to result for n + 1 reads on the single read port
//  of the vertex store, then while the three-stage compare pipeline drains;
//  an n below three answers in the cycle after dispatch.
//  A test is dispatched only once the previous result is taken.
//  Reset clears the queue, the control state and vertex_count; the vertex
//  store itself is not cleared and holds garbage until written.
//  A two-entry queue lets the input keep accepting beats while the back end
//  walks edges or while a finished result waits under out_stall.
//
module point_in_polygon_test_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [pip_pkg::COUNT_W-1:0]            cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pip_pkg::CMD_W-1:0]              command,
    input  logic [pip_pkg::IDX_W-1:0]              vertex_index,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   inside_res
);
    import pip_pkg::*;

    // Queue interface between the front and the back end.
    logic      q_valid;
    pip_item_t q_item;
    logic      q_pop;

    // The front accepts beats and filters writes to nonexistent slots.
    pip_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // The back end owns the vertex store, the count register and the
    // crossing pipeline, and drives the result register.
    pip_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res)
    );

endmodule

/* dv/point_in_polygon_test_unit_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// point_in_polygon_test_unit_checker: result predictor and scoreboard
// Watches the register port and both channels of the point-in-polygon unit.
// It mirrors the vertex store and the vertex count and predicts the inside
// flag of every test beat. It then compares each result beat with the oldest
// prediction and hands the failure count and the open predictions to the top.
// ============================================================================
module point_in_polygon_test_unit_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [pip_pkg::COUNT_W-1:0]            cfg_wr_data,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [pip_pkg::CMD_W-1:0]              command,
    input  logic [pip_pkg::IDX_W-1:0]              vertex_index,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic                                   inside_res,
    output int                                     mismatch_count,
    output int                                     awaiting
);
    import pip_pkg::*;

    logic signed [COORD_WIDTH-1:0] corner_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] corner_y [MAX_VERTICES];
    logic [COUNT_W-1:0]            poly_count;
    logic                          inside_expected [$];

    // Even-odd crossing count with the crossing x compared exactly by
    // cross-multiplication; the compare turns around for a falling edge.
    function automatic logic even_odd_inside(input logic signed [COORD_WIDTH-1:0] px,
                                             input logic signed [COORD_WIDTH-1:0] py);
        int      used;
        int      j;
        logic    odd;
        longint  qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
        used = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        odd  = 1'b0;
        qx   = px;
        qy   = py;
        if (used >= MIN_POLY_VERTICES) begin
            j = used - 1;
            for (int i = 0; i < used; i++) begin
                xi = corner_x[i];
                yi = corner_y[i];
                xj = corner_x[j];
                yj = corner_y[j];
                if ((yi > qy) != (yj > qy)) begin
                    dy  = yj - yi;
                    lhs = (qx - xi) * dy;
                    rhs = (xj - xi) * (qy - yi);
                    if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs))
                        odd = ~odd;
                end
                j = i;
            end
        end
        return odd;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            poly_count = '0;
            inside_expected.delete();
            awaiting = 0;
        end
        else begin
            if (cfg_wr_en)
                poly_count = cfg_wr_data;

            if (out_valid && !out_stall) begin
                if (inside_expected.size() == 0) begin
                    $display("%0t: inside_res beat with no test open, expected none, got %0b",
                             $time, inside_res);
                    mismatch_count++;
                end
                else begin
                    if (inside_res !== inside_expected[0]) begin
                        $display("%0t: inside_res mismatch, expected %0b, got %0b",
                                 $time, inside_expected[0], inside_res);
                        mismatch_count++;
                    end
                    void'(inside_expected.pop_front());
                end
            end

            if (in_valid && !in_stall) begin
                if (command == CMD_WRITE) begin
                    corner_x[vertex_index] = coord_x;
                    corner_y[vertex_index] = coord_y;
                end
                else begin
                    inside_expected.insert(inside_expected.size(),
                                           even_odd_inside(coord_x, coord_y));
                end
            end
            awaiting = inside_expected.size();
        end
    end

endmodule

/* dv/point_in_polygon_test_unit_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// point_in_polygon_test_unit_test: top of the point-in-polygon testbench
// Drives vertex writes, point tests and vertex-count settings into the unit,
// stalls the result side at random and gives the verdict. Prediction and
// comparison live in the checker instantiated beside the unit.
// ============================================================================
module point_in_polygon_test_unit_test;
    import pip_pkg::*;

    // The slowest phase walks every edge of the full store for each test; this
    // limit still leaves a wide margin over what a correct run needs.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PERCENT = 35;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_wr_en    = 1'b0;
    logic [COUNT_W-1:0]            cfg_wr_data  = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [CMD_W-1:0]              command      = CMD_WRITE;
    logic [IDX_W-1:0]              vertex_index = '0;
    logic signed [COORD_WIDTH-1:0] coord_x      = '0;
    logic signed [COORD_WIDTH-1:0] coord_y      = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic                          inside_res;

    int mismatch_count;
    int awaiting;
    int cycle_count = 0;

    // While quiet is set, neither side idles: beats go back to back.
    logic quiet = 1'b0;

    // Stimulus-side copy of the polygon, used only to aim query points at
    // vertex rows and columns, where the crossing rule has its corner cases.
    logic signed [COORD_WIDTH-1:0] aim_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] aim_y [MAX_VERTICES];

    point_in_polygon_test_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inside_res   (inside_res)
    );

    point_in_polygon_test_unit_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .vertex_index   (vertex_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .inside_res     (inside_res),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The result side stalls in about a third of the cycles, except in the
    // quiet stretch. Stall changes only at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** point_in_polygon_test_unit: FAILED **");
            $finish;
        end
    end

    // A coordinate spread around a center, clamped to the signed Q12.4 range.
    function automatic logic signed [COORD_WIDTH-1:0] near(input int center, input int radius);
        int v;
        v = center + int'($urandom_range(0, 2 * radius)) - radius;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_WIDTH-1:0];
    endfunction

    // One input beat. The task is entered at a falling edge and returns at
    // the falling edge after acceptance, with valid still high so that the
    // next beat can follow without a gap.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input int idx,
                             input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        vertex_index <= idx[IDX_W-1:0];
        coord_x      <= x;
        coord_y      <= y;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic put_vertex(input int idx, input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y);
        aim_x[idx] = x;
        aim_y[idx] = y;
        send_beat(CMD_WRITE, idx, x, y);
    endtask

    task automatic test_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y);
        send_beat(CMD_TEST, $urandom_range(0, 63), x, y);
    endtask

    // The vertex count is only changed with the unit idle: every test has
    // answered, and a pending vertex write has had time to land.
    task automatic set_vertex_count(input int count);
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count[COUNT_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Vertex counts of the first random phases, chosen to hit the edges of
    // the register: the smallest polygon, the full store, counts above the
    // store size, and the counts that always answer outside.
    function automatic int scheduled_count(input int phase);
        case (phase)
            0:       return 3;
            1:       return 64;
            2:       return 127;
            3:       return 0;
            4:       return 4;
            5:       return 2;
            6:       return 65;
            7:       return 1;
            8:       return 5;
            9:       return 96;
            default:
            begin
                if ($urandom_range(0, 9) < 8)
                    return $urandom_range(3, 10);
                else if ($urandom_range(0, 1) == 0)
                    return $urandom_range(0, 2);
                return $urandom_range(11, 127);
            end
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int count;
        int used;
        int budget;
        int center_x;
        int center_y;
        int radius;
        int roll;
        int k;
        logic signed [COORD_WIDTH-1:0] qx;
        logic signed [COORD_WIDTH-1:0] qy;

        // Reset is held from the start and released on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With no polygon in use, every test answers outside.
        set_vertex_count(0);
        test_point(-16'sd32768, -16'sd32768);
        test_point(16'sd32767, 16'sd32767);

        // A square spanning the whole coordinate range. Points on its left
        // and bottom edges count as inside, points on its right and top
        // edges as outside, which exercises the strict compares.
        set_vertex_count(4);
        put_vertex(0, -16'sd32768, -16'sd32768);
        put_vertex(1, 16'sd32767, -16'sd32768);
        put_vertex(2, 16'sd32767, 16'sd32767);
        put_vertex(3, -16'sd32768, 16'sd32767);
        put_vertex(63, 16'sd32767, -16'sd32768);
        test_point(16'sd0, 16'sd0);
        test_point(-16'sd1, -16'sd1);
        test_point(-16'sd32768, 16'sd0);
        test_point(16'sd32767, 16'sd0);
        test_point(16'sd0, -16'sd32768);
        test_point(16'sd0, 16'sd32767);
        test_point(-16'sd32768, -16'sd32768);
        test_point(16'sd32767, 16'sd32767);

        // A triangle with a horizontal edge and a vertex on the query
        // row, where the ray passes exactly through a corner.
        set_vertex_count(3);
        put_vertex(0, 16'sd0, 16'sd0);
        put_vertex(1, 16'sd160, 16'sd0);
        put_vertex(2, 16'sd80, 16'sd160);
        test_point(16'sd80, 16'sd0);
        test_point(-16'sd16, 16'sd160);
        test_point(16'sd79, 16'sd159);

        // Random part: each phase sets a count, lays down a fresh polygon in
        // every slot in use, then mixes tests with vertex rewrites. Tests are
        // only issued once every slot in use has been written.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            count = scheduled_count(phase);
            used  = (count > MAX_VERTICES) ? MAX_VERTICES : count;
            set_vertex_count(count);

            // One phase runs with no idling on either side at all.
            quiet = (phase == 4);

            case ($urandom_range(0, 2))
                0:       radius = 8;
                1:       radius = 200;
                default: radius = 32767;
            endcase
            if (radius == 32767) begin
                center_x = 0;
                center_y = 0;
            end
            else begin
                center_x = int'($urandom_range(0, 65535)) - 32768;
                center_y = int'($urandom_range(0, 65535)) - 32768;
            end

            for (int v = 0; v < used; v++) begin
                put_vertex(v, near(center_x, radius), near(center_y, radius));
                sent++;
            end

            budget = (used > 16) ? 40 : 120;
            if (quiet)
                budget = 150;

            repeat (budget) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    k  = (used > 0) ? $urandom_range(0, used - 1) : 0;
                    qx = near(center_x, radius);
                    qy = near(center_y, radius);
                    if (used > 0) begin
                        case ($urandom_range(0, 5))
                            2: qy = aim_y[k];
                            3:
                            begin
                                qx = aim_x[k];
                                qy = aim_y[k];
                            end
                            4: qx = aim_x[k];
                            5:
                            begin
                                qx = COORD_WIDTH'($urandom());
                                qy = COORD_WIDTH'($urandom());
                            end
                            default: ;
                        endcase
                    end
                    test_point(qx, qy);
                end
                else if (roll < 88 && used > 0) begin
                    put_vertex($urandom_range(0, used - 1), near(center_x, radius),
                               near(center_y, radius));
                end
                else begin
                    put_vertex($urandom_range(0, 63), COORD_WIDTH'($urandom()),
                               COORD_WIDTH'($urandom()));
                end
                sent++;
            end

            quiet = 1'b0;
            phase++;
        end

        // Let every open test answer, then allow the pipeline to settle so
        // that a stray extra beat would still be caught.
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaiting == 0)
            $display("** point_in_polygon_test_unit: PASSED **");
        else
            $display("** point_in_polygon_test_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
src/pip_pkg.sv
src/pip_ram.sv
src/pip_front.sv
src/pip_back.sv
src/point_in_polygon_test_unit.sv
dv/point_in_polygon_test_unit_checker.sv
dv/point_in_polygon_test_unit_test.sv
